@@ rtl/bmgf_pkg.sv @@
`default_nettype none

package bmgf_pkg;

    // Sample format
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 12;

    // Configuration register
    localparam int                  INV_DX_W     = 16;
    localparam logic [INV_DX_W-1:0] INV_DX_RESET = INV_DX_W'(256);

    // Derived datapath widths
    localparam int DIFF_W    = SAMPLE_WIDTH + 1;        // neighbour difference, limited slope
    localparam int W_W       = SAMPLE_WIDTH + 2;        // interface state 2*u +/- slope
    localparam int MAG_W     = SAMPLE_WIDTH + 1;        // magnitude of an interface state
    localparam int SQ_W      = 2 * MAG_W;               // square of that magnitude
    localparam int PROD_W    = SQ_W + INV_DX_W;         // flux difference times inv_dx
    localparam int RND_SHIFT = FRAC_BITS + 11;          // 1/8 of the square, Q8.8 scale
    localparam int Q_W       = PROD_W + 1 - RND_SHIFT;  // rounded magnitude

    // Result
    localparam int OUT_W = 32;

    // Window geometry
    localparam int WIN_DEPTH = 5;
    localparam int FILL_W    = 3;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // transfer on the input channel: shift the window
        logic recon;     // slopes, interface states, Godunov magnitudes
        logic sq_p;      // square the right-interface magnitude
        logic sq_m;      // square the left-interface magnitude, take the difference
        logic mul;       // scale by inv_dx
        logic load_out;  // round, saturate, load the result register
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/bmgf_ctrl.sv @@
`default_nettype none

module bmgf_ctrl import bmgf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_row_start,
    input  wire logic i_out_stall,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RECON = 6'b000010,
        S_SQP   = 6'b000100,
        S_SQM   = 6'b001000,
        S_MUL   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state, fill count and result valid
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_row_start) begin
                        n_fill = FILL_W'(1);
                    end else if (r_fill == FILL_FULL) begin
                        n_state = S_RECON;
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
            end
            S_RECON: begin
                o_cmd.recon = 1'b1;
                n_state     = S_SQP;
            end
            S_SQP: begin
                o_cmd.sq_p = 1'b1;
                n_state    = S_SQM;
            end
            S_SQM: begin
                o_cmd.sq_m = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !(r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/bmgf_dp.sv @@
`default_nettype none

module bmgf_dp import bmgf_pkg::*; (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_cmd                           i_cmd,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_inv_dx_we,
    input  wire logic        [INV_DX_W-1:0]     i_inv_dx,
    output logic signed      [OUT_W-1:0]        o_flux_derivative
);

    localparam logic [PROD_W:0] HALF    = (PROD_W + 1)'(1) << (RND_SHIFT - 1);
    localparam logic [63:0]     POS_LIM = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0]     NEG_LIM = 64'h0000_0000_8000_0000;

    // minmod of two differences
    function automatic logic signed [DIFF_W-1:0] minmod(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        logic signed [DIFF_W-1:0] res;
        res = '0;
        if (a > 0 && b > 0) begin
            res = (a < b) ? a : b;
        end else if (a < 0 && b < 0) begin
            res = (a > b) ? a : b;
        end
        return res;
    endfunction

    function automatic logic [MAG_W-1:0] abs_w(input logic signed [W_W-1:0] w);
        logic [W_W-1:0] m;
        m = (w < 0) ? W_W'(-w) : W_W'(w);
        return m[MAG_W-1:0];
    endfunction

    // Godunov flux for u*u/2: the magnitude whose square is the flux
    function automatic logic [MAG_W-1:0] godunov_mag(
        input logic signed [W_W-1:0] wl,
        input logic signed [W_W-1:0] wr
    );
        logic [MAG_W-1:0] al;
        logic [MAG_W-1:0] ar;
        logic [MAG_W-1:0] res;
        al  = abs_w(wl);
        ar  = abs_w(wr);
        res = '0;
        if (wl <= wr) begin
            if (wl >= 0) begin
                res = al;
            end else if (wr <= 0) begin
                res = ar;
            end
        end else begin
            res = (al > ar) ? al : ar;
        end
        return res;
    endfunction

    logic        [INV_DX_W-1:0]     r_inv_dx;
    logic signed [SAMPLE_WIDTH-1:0] r_win [WIN_DEPTH];
    logic        [MAG_W-1:0]        r_mag_p;
    logic        [MAG_W-1:0]        r_mag_m;
    logic        [SQ_W-1:0]         r_sq_p;
    logic        [SQ_W-1:0]         r_diff;
    logic                           r_neg;
    logic        [PROD_W-1:0]       r_prod;
    logic signed [OUT_W-1:0]        r_flux;

    logic signed [DIFF_W-1:0] d0, d1, d2, d3;
    logic signed [DIFF_W-1:0] s1, s2, s3;
    logic signed [W_W-1:0]    wl_p, wr_p, wl_m, wr_m;
    logic        [MAG_W-1:0]  sq_op;
    logic        [SQ_W-1:0]   sq;
    logic                     sq_neg;
    logic        [PROD_W:0]   rnd;
    logic        [Q_W-1:0]    q;
    logic        [63:0]       q64;
    logic signed [OUT_W-1:0]  flux_sat;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_dx <= INV_DX_RESET;
        end else if (i_inv_dx_we) begin
            r_inv_dx <= i_inv_dx;
        end
    end

    // Reconstruction from the five-sample window, centre at index 2
    always_comb begin
        d0   = DIFF_W'(r_win[1]) - DIFF_W'(r_win[0]);
        d1   = DIFF_W'(r_win[2]) - DIFF_W'(r_win[1]);
        d2   = DIFF_W'(r_win[3]) - DIFF_W'(r_win[2]);
        d3   = DIFF_W'(r_win[4]) - DIFF_W'(r_win[3]);
        s1   = minmod(d1, d0);
        s2   = minmod(d2, d1);
        s3   = minmod(d3, d2);
        wl_p = W_W'(r_win[2]) + W_W'(r_win[2]) + W_W'(s2);
        wr_p = W_W'(r_win[3]) + W_W'(r_win[3]) - W_W'(s3);
        wl_m = W_W'(r_win[1]) + W_W'(r_win[1]) + W_W'(s1);
        wr_m = W_W'(r_win[2]) + W_W'(r_win[2]) - W_W'(s2);
    end

    // Shared squarer
    assign sq_op  = i_cmd.sq_p ? r_mag_p : r_mag_m;
    assign sq     = sq_op * sq_op;
    assign sq_neg = r_sq_p < sq;

    // Round to nearest, ties away from zero, then saturate
    always_comb begin
        rnd = {1'b0, r_prod} + HALF;
        q   = rnd[PROD_W:RND_SHIFT];
        q64 = 64'(q);
        if (!r_neg) begin
            flux_sat = (q64 > POS_LIM) ? OUT_W'(POS_LIM) : OUT_W'(q64);
        end else begin
            flux_sat = (q64 > NEG_LIM) ? OUT_W'(NEG_LIM) : OUT_W'(64'd0 - q64);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[WIN_DEPTH-1] <= i_sample;
        end
        if (i_cmd.recon) begin
            r_mag_p <= godunov_mag(wl_p, wr_p);
            r_mag_m <= godunov_mag(wl_m, wr_m);
        end
        if (i_cmd.sq_p) begin
            r_sq_p <= sq;
        end
        if (i_cmd.sq_m) begin
            r_neg  <= sq_neg;
            r_diff <= sq_neg ? (sq - r_sq_p) : (r_sq_p - sq);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_diff) * PROD_W'(r_inv_dx);
        end
        if (i_cmd.load_out) begin
            r_flux <= flux_sat;
        end
    end

    assign o_flux_derivative = r_flux;

endmodule

`default_nettype wire

@@ rtl/burgers_muscl_godunov_flux_core.sv @@
`default_nettype none

// Channel   Direction  Transfer when               Payload
// input     in         i_in_valid & !o_in_stall    i_sample, i_row_start
// output    out        o_out_valid & !i_out_stall  o_flux_derivative
// config    in         i_inv_dx_we                 i_inv_dx
//
// A sample that fills the window or opens a row does not stall the input; the next may follow at once.
// A sample that completes a full window steps through recon, both squares and multiply to the
// result register, waiting on a stalled result; one squarer serves both interfaces in turn.
// Input stall is high from the cycle after such a transfer until the result is loaded.
// Synchronous active-low reset clears the controller, the fill count and inv_dx (1.0).

module burgers_muscl_godunov_flux_core import bmgf_pkg::*; (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_row_start,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed      [OUT_W-1:0]        o_flux_derivative,
    input  wire logic                           i_inv_dx_we,
    input  wire logic        [INV_DX_W-1:0]     i_inv_dx
);

    t_cmd cmd;

    bmgf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_row_start (i_row_start),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    bmgf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_sample          (i_sample),
        .i_inv_dx_we       (i_inv_dx_we),
        .i_inv_dx          (i_inv_dx),
        .o_flux_derivative (o_flux_derivative)
    );

    // At most one datapath step per cycle
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result register loaded while a result is held");

    // Squares follow reconstruction in order
    a_sq_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.recon |=> cmd.sq_p ##1 cmd.sq_m ##1 cmd.mul)
        else $error("datapath sequence broken");

    // No input transfer while an item is in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.recon || cmd.sq_p || cmd.sq_m || cmd.mul) |-> o_in_stall)
        else $error("input open while an item is in work");

endmodule

`default_nettype wire
